>>> rtl/dbst_pkg.sv
package dbst_pkg;

  localparam int NameBufferLenDefault = 12;
  localparam int CountBitsDefault     = 16;
  localparam int ResMax               = 4;
  localparam int KwCount              = 35;
  localparam int KwMaxLen             = 11;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_NAME    = 12'b0000_0000_0010,
    M_DOLLAR0 = 12'b0000_0000_0100,
    M_DOLLAR  = 12'b0000_0000_1000,
    M_NUM     = 12'b0000_0001_0000,
    M_NUM_DOT = 12'b0000_0010_0000,
    M_STR     = 12'b0000_0100_0000,
    M_EQ      = 12'b0000_1000_0000,
    M_LT      = 12'b0001_0000_0000,
    M_GT      = 12'b0010_0000_0000,
    M_BANG    = 12'b0100_0000_0000,
    M_DASH    = 12'b1000_0000_0000
  } scan_mode_t;

  localparam logic [4:0] TkKeyword  = 5'd0;
  localparam logic [4:0] TkName     = 5'd1;
  localparam logic [4:0] TkDollar   = 5'd2;
  localparam logic [4:0] TkInt      = 5'd3;
  localparam logic [4:0] TkFloat    = 5'd4;
  localparam logic [4:0] TkTimeUnit = 5'd5;
  localparam logic [4:0] TkString   = 5'd6;
  localparam logic [4:0] TkEq       = 5'd7;
  localparam logic [4:0] TkEqEq     = 5'd8;
  localparam logic [4:0] TkLt       = 5'd9;
  localparam logic [4:0] TkLe       = 5'd10;
  localparam logic [4:0] TkGt       = 5'd11;
  localparam logic [4:0] TkGe       = 5'd12;
  localparam logic [4:0] TkNe       = 5'd13;
  localparam logic [4:0] TkLBrace   = 5'd14;
  localparam logic [4:0] TkRBrace   = 5'd15;
  localparam logic [4:0] TkLParen   = 5'd16;
  localparam logic [4:0] TkRParen   = 5'd17;
  localparam logic [4:0] TkLBracket = 5'd18;
  localparam logic [4:0] TkRBracket = 5'd19;
  localparam logic [4:0] TkComma    = 5'd20;
  localparam logic [4:0] TkDot      = 5'd21;
  localparam logic [4:0] TkArrow    = 5'd22;
  localparam logic [4:0] TkEnd      = 5'd23;
  localparam logic [4:0] TkInvalid  = 5'd24;

  typedef struct packed {
    logic [4:0]  cls;
    logic [5:0]  kw;
    logic [31:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } tok_t;

  localparam logic [87:0] KwText [KwCount] = '{
    88'("LOAD"), 88'("FROM"), 88'("SET"), 88'("WINDOW"), 88'("TREND"),
    88'("FORECAST"), 88'("USING"), 88'("STREAM"), 88'("SELECT"), 88'("WHERE"),
    88'("DATE"), 88'("AS"), 88'("PLOT"), 88'("EXPORT"), 88'("TO"),
    88'("FOR"), 88'("IN"), 88'("REMOVE"), 88'("MISSING"), 88'("REPLACE"),
    88'("WITH"), 88'("ANALYZE"), 88'("BASED_ON"), 88'("BELOW"), 88'("ABOVE"),
    88'("MEAN"), 88'("MEDIAN"), 88'("TENDENCY"), 88'("ARIMA"), 88'("PROPHET"),
    88'("LSTM"), 88'("LINEPLOT"), 88'("HISTOGRAM"), 88'("SCATTERPLOT"),
    88'("BARPLOT")
  };

  localparam logic [3:0] KwLen [KwCount] = '{
    4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd8, 4'd5, 4'd6, 4'd6, 4'd5,
    4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd3, 4'd2, 4'd6, 4'd7, 4'd7,
    4'd4, 4'd7, 4'd8, 4'd5, 4'd5, 4'd4, 4'd6, 4'd8, 4'd5, 4'd7,
    4'd4, 4'd8, 4'd9, 4'd11, 4'd7
  };

endpackage

>>> rtl/dsl_byte_stream_tokenizer_top.sv
// Byte-stream tokenizer: takes source text one byte per word on the input
// channel and delivers tokens (class, keyword number, offset, length, line,
// column) on the output channel, last_of_run flagging the final token that a
// byte caused. A byte is classified and the token state advanced as the byte
// is taken, with names matched against all 35 keywords in parallel; so a new
// byte is taken every cycle while the output keeps up. A byte that yields k
// tokens (up to four, e.g. a trailing number, dot, pending symbol and end
// token) holds the input until they drain, since the output queue hands out
// one token per cycle while out_ready is high and is refilled only as its
// last token leaves. Set end_of_text on the final byte:
// any pending token and then an end token follow, after which all counters
// return to their reset values.
module dsl_byte_stream_tokenizer_top import dbst_pkg::*; #(
  parameter int NAME_BUFFER_LEN = NameBufferLenDefault,
  parameter int COUNT_BITS      = CountBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  token_class,
  output logic [5:0]  keyword_index,
  output logic [31:0] token_offset,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic        last_of_run
);

  tok_t       res [ResMax];
  logic [2:0] res_cnt;
  tok_t       head;
  logic       fire;

  // Take a byte only when the whole token group it may raise fits.
  assign fire = in_valid && in_ready;

  dbst_scan #(
    .NAME_BUFFER_LEN (NAME_BUFFER_LEN),
    .COUNT_BITS      (COUNT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .res         (res),
    .res_cnt     (res_cnt)
  );

  // Queue of tokens raised by the last byte; drain one word per cycle while out_ready is high.
  dbst_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .items     (res),
    .cnt       (res_cnt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free_next (in_ready),
    .head      (head)
  );

  assign token_class   = head.cls;
  assign keyword_index = head.kw;
  assign token_offset  = head.offset;
  assign token_length  = head.length;
  assign token_line    = head.line;
  assign token_column  = head.column;
  assign last_of_run   = head.last;

  // The final byte always raises at least the end token.
  assert property (@(posedge clk) disable iff (rst)
    fire && end_of_text |=> out_valid)
    else $error("no token after final byte");

  // The end token closes its group.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_class == TkEnd |-> last_of_run)
    else $error("end token not last of run");

  // A byte is never taken while tokens would be left behind in the queue.
  assert property (@(posedge clk) disable iff (rst)
    fire |-> !out_valid || (out_ready && last_of_run))
    else $error("byte taken over pending tokens");

endmodule

>>> rtl/dbst_kw_match.sv
module dbst_kw_match import dbst_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic [KwMaxLen*8-1:0]  name_view,
  input  logic [COUNT_BITS-1:0]  name_len,
  output logic                   hit,
  output logic [5:0]             kw_idx
);

  // Compare against every keyword at once; lowest index wins.
  always_comb begin
    logic eq;
    hit    = 1'b0;
    kw_idx = '0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      eq = (name_len == COUNT_BITS'(KwLen[k]));
      for (int i = 0; i < KwMaxLen; i++) begin
        if (i < int'(KwLen[k])) begin
          eq = eq && (name_view[i*8 +: 8] ==
                      KwText[k][(int'(KwLen[k]) - 1 - i)*8 +: 8]);
        end
      end
      if (eq) begin
        hit    = 1'b1;
        kw_idx = 6'(k);
      end
    end
  end

endmodule

>>> rtl/dbst_scan.sv
module dbst_scan import dbst_pkg::*; #(
  parameter int NAME_BUFFER_LEN = NameBufferLenDefault,
  parameter int COUNT_BITS      = CountBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output tok_t       res [ResMax],
  output logic [2:0] res_cnt
);

  localparam int IW = $clog2(NAME_BUFFER_LEN);
  localparam logic [COUNT_BITS-1:0] CMax = '1;

  scan_mode_t            mode, mode_next;
  logic [COUNT_BITS-1:0] line, line_next, col, col_next, run, run_next;
  logic [COUNT_BITS-1:0] scol, scol_next;
  logic [31:0]           bcnt, bcnt_next, soff, soff_next;
  logic                  fseen, fseen_next;
  logic [7:0]            name_chars [NAME_BUFFER_LEN];

  logic                  is_al, is_dg, is_wd, is_sp, cons;
  logic                  wen;
  logic [IW-1:0]         widx;
  logic [7:0]            wch;
  logic [COUNT_BITS-1:0] run_view;
  logic [KwMaxLen*8-1:0] view;
  logic                  kw_hit;
  logic [5:0]            kw_idx;

  function automatic logic [COUNT_BITS-1:0] inc_c(input logic [COUNT_BITS-1:0] v);
    return (v == CMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] inc_b(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic tok_t mk(input logic [4:0] cls, input logic [5:0] kw,
                              input logic [31:0] off, input logic [COUNT_BITS-1:0] len,
                              input logic [COUNT_BITS-1:0] ln,
                              input logic [COUNT_BITS-1:0] cc);
    tok_t t;
    t.cls    = cls;
    t.kw     = kw;
    t.offset = off;
    t.length = 16'(len);
    t.line   = 16'(ln);
    t.column = 16'(cc);
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [COUNT_BITS-1:0] back_col(input logic [COUNT_BITS-1:0] cc,
                                                     input logic [COUNT_BITS-1:0] len);
    return (cc >= len) ? cc - len : '0;
  endfunction

  function automatic logic [4:0] single_cls(input logic [7:0] c);
    case (c)
      8'h7B:   return TkLBrace;
      8'h7D:   return TkRBrace;
      8'h28:   return TkLParen;
      8'h29:   return TkRParen;
      8'h5B:   return TkLBracket;
      8'h5D:   return TkRBracket;
      8'h2C:   return TkComma;
      8'h2E:   return TkDot;
      default: return TkInvalid;
    endcase
  endfunction

  assign is_al = (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
                 (text_byte >= 8'h41 && text_byte <= 8'h5A);
  assign is_dg = text_byte >= 8'h30 && text_byte <= 8'h39;
  assign is_wd = is_al || is_dg || text_byte == 8'h5F;
  assign is_sp = text_byte == 8'h20 || (text_byte >= 8'd9 && text_byte <= 8'd13);
  assign wch   = (text_byte >= 8'h61 && text_byte <= 8'h7A) ? text_byte - 8'd32 : text_byte;

  // Does the pending token swallow this byte?
  always_comb begin
    cons = 1'b0;
    unique case (mode)
      M_NAME, M_DOLLAR: cons = is_wd;
      M_DOLLAR0:        cons = is_al || text_byte == 8'h5F;
      M_NUM_DOT:        cons = is_dg;
      M_NUM:            cons = is_dg || (text_byte == 8'h2E && !fseen) ||
                               text_byte == 8'h64 || text_byte == 8'h68 ||
                               text_byte == 8'h6D;
      M_STR:            cons = 1'b1;
      M_EQ, M_LT, M_GT, M_BANG: cons = text_byte == 8'h3D;
      M_DASH:           cons = text_byte == 8'h3E;
      default:          cons = 1'b0;
    endcase
  end

  // Name buffer write, and the buffer as it stands after this byte.
  always_comb begin
    wen  = 1'b0;
    widx = '0;
    if (mode == M_NAME) begin
      run_view = is_wd ? inc_c(run) : run;
      if (is_wd && run < COUNT_BITS'(NAME_BUFFER_LEN)) begin
        wen  = 1'b1;
        widx = run[IW-1:0];
      end
    end else begin
      run_view = COUNT_BITS'(1);
      if (!cons && (is_al || text_byte == 8'h5F)) begin
        wen = 1'b1;
      end
    end
    for (int i = 0; i < KwMaxLen; i++) begin
      view[i*8 +: 8] = (wen && widx == IW'(i)) ? wch : name_chars[i];
    end
  end

  dbst_kw_match #(.COUNT_BITS(COUNT_BITS)) u_kw (
    .name_view (view),
    .name_len  (run_view),
    .hit       (kw_hit),
    .kw_idx    (kw_idx)
  );

  always_comb begin
    logic [2:0] n;
    logic [4:0] nc;
    n = '0;
    nc = TkInvalid;
    for (int i = 0; i < ResMax; i++) res[i] = '0;
    mode_next  = mode;
    line_next  = line;
    col_next   = col;
    bcnt_next  = bcnt;
    soff_next  = soff;
    scol_next  = scol;
    run_next   = run;
    fseen_next = fseen;

    unique case (mode)
      M_NAME: begin
        if (is_wd) begin
          run_next = inc_c(run_next);
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        end else begin
          res[n[1:0]] = mk(kw_hit ? TkKeyword : TkName, kw_hit ? kw_idx : 6'd0,
                           soff_next, run_next, line_next,
                           back_col(col_next, run_next));
          n = n + 3'd1;
        end
      end
      M_DOLLAR0: begin
        if (cons) begin
          run_next = COUNT_BITS'(1);
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          mode_next = M_DOLLAR;
        end else begin
          res[n[1:0]] = mk(TkInvalid, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                           back_col(col_next, COUNT_BITS'(1)));
          n = n + 3'd1;
        end
      end
      M_DOLLAR: begin
        if (is_wd) begin
          run_next = inc_c(run_next);
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        end else begin
          res[n[1:0]] = mk(TkDollar, 6'd0, inc_b(soff_next), run_next, line_next,
                           scol_next);
          n = n + 3'd1;
        end
      end
      M_NUM_DOT: begin
        if (is_dg) begin
          run_next = inc_c(inc_c(run_next));
          col_next = inc_c(inc_c(col_next));
          bcnt_next = inc_b(inc_b(bcnt_next));
          fseen_next = 1'b1;
          mode_next = M_NUM;
        end else begin
          res[n[1:0]] = mk(fseen_next ? TkFloat : TkInt, 6'd0, soff_next, run_next,
                           line_next, back_col(col_next, run_next));
          n = n + 3'd1;
          soff_next = bcnt_next;
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          res[n[1:0]] = mk(TkDot, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                           back_col(col_next, COUNT_BITS'(1)));
          n = n + 3'd1;
        end
      end
      M_NUM: begin
        if (is_dg) begin
          run_next = inc_c(run_next);
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        end else if (text_byte == 8'h2E && !fseen) begin
          mode_next = M_NUM_DOT;
        end else if (cons) begin
          run_next = inc_c(run_next);
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          res[n[1:0]] = mk(TkTimeUnit, 6'd0, soff_next, run_next, line_next,
                           back_col(col_next, run_next));
          n = n + 3'd1;
          mode_next = M_IDLE;
        end else begin
          res[n[1:0]] = mk(fseen_next ? TkFloat : TkInt, 6'd0, soff_next, run_next,
                           line_next, back_col(col_next, run_next));
          n = n + 3'd1;
        end
      end
      M_STR: begin
        if (text_byte == 8'h22) begin
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          res[n[1:0]] = mk(TkString, 6'd0, soff_next, run_next, line_next,
                           back_col(col_next, run_next));
          n = n + 3'd1;
          mode_next = M_IDLE;
        end else begin
          if (text_byte == 8'h0A) line_next = inc_c(line_next);
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          run_next = inc_c(run_next);
        end
      end
      M_EQ, M_LT, M_GT, M_BANG: begin
        if (cons) begin
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          nc = (mode == M_EQ) ? TkEqEq : (mode == M_LT) ? TkLe :
               (mode == M_GT) ? TkGe : TkNe;
          res[n[1:0]] = mk(nc, 6'd0, soff_next, COUNT_BITS'(2), line_next,
                           back_col(col_next, COUNT_BITS'(2)));
          n = n + 3'd1;
          mode_next = M_IDLE;
        end else begin
          nc = (mode == M_EQ) ? TkEq : (mode == M_LT) ? TkLt :
               (mode == M_GT) ? TkGt : TkInvalid;
          res[n[1:0]] = mk(nc, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                           back_col(col_next, COUNT_BITS'(1)));
          n = n + 3'd1;
        end
      end
      M_DASH: begin
        if (cons) begin
          col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
          res[n[1:0]] = mk(TkArrow, 6'd0, soff_next, COUNT_BITS'(2), line_next,
                           back_col(col_next, COUNT_BITS'(2)));
          n = n + 3'd1;
          mode_next = M_IDLE;
        end else begin
          res[n[1:0]] = mk(TkInvalid, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                           back_col(col_next, COUNT_BITS'(1)));
          n = n + 3'd1;
        end
      end
      default: ;
    endcase

    // Byte not taken by a pending token: start afresh from idle.
    if (!cons) begin
      mode_next = M_IDLE;
      soff_next = bcnt_next;
      if (is_sp) begin
        if (text_byte == 8'h0A) begin
          line_next = inc_c(line_next);
          col_next  = COUNT_BITS'(1);
        end else begin
          col_next = inc_c(col_next);
        end
        bcnt_next = inc_b(bcnt_next);
      end else if (text_byte == 8'h24) begin
        col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        scol_next = col_next;
        mode_next = M_DOLLAR0;
      end else if (is_al || text_byte == 8'h5F) begin
        run_next = COUNT_BITS'(1);
        col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        mode_next = M_NAME;
      end else if (is_dg) begin
        run_next = COUNT_BITS'(1);
        fseen_next = 1'b0;
        col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        mode_next = M_NUM;
      end else if (text_byte == 8'h22) begin
        col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        soff_next = bcnt_next;
        run_next = '0;
        mode_next = M_STR;
      end else begin
        col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
        case (text_byte)
          8'h3D: mode_next = M_EQ;
          8'h3C: mode_next = M_LT;
          8'h3E: mode_next = M_GT;
          8'h21: mode_next = M_BANG;
          8'h2D: mode_next = M_DASH;
          default: begin
            res[n[1:0]] = mk(single_cls(text_byte), 6'd0, soff_next, COUNT_BITS'(1),
                             line_next, back_col(col_next, COUNT_BITS'(1)));
            n = n + 3'd1;
          end
        endcase
      end
    end

    // Final byte: flush the pending token, then the end token, then reset.
    if (end_of_text) begin
      unique case (mode_next)
        M_NAME: begin
          res[n[1:0]] = mk(kw_hit ? TkKeyword : TkName, kw_hit ? kw_idx : 6'd0,
                           soff_next, run_next, line_next,
                           back_col(col_next, run_next));
          n = n + 3'd1;
        end
        M_DOLLAR0, M_DASH: begin
          res[n[1:0]] = mk(TkInvalid, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                           back_col(col_next, COUNT_BITS'(1)));
          n = n + 3'd1;
        end
        M_DOLLAR: begin
          res[n[1:0]] = mk(TkDollar, 6'd0, inc_b(soff_next), run_next, line_next,
                           scol_next);
          n = n + 3'd1;
        end
        M_NUM, M_NUM_DOT: begin
          res[n[1:0]] = mk(fseen_next ? TkFloat : TkInt, 6'd0, soff_next, run_next,
                           line_next, back_col(col_next, run_next));
          n = n + 3'd1;
          if (mode_next == M_NUM_DOT) begin
            soff_next = bcnt_next;
            col_next = inc_c(col_next); bcnt_next = inc_b(bcnt_next);
            res[n[1:0]] = mk(TkDot, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                             back_col(col_next, COUNT_BITS'(1)));
            n = n + 3'd1;
          end
        end
        M_STR: begin
          col_next = inc_c(col_next);
          res[n[1:0]] = mk(TkString, 6'd0, soff_next, run_next, line_next,
                           back_col(col_next, run_next));
          n = n + 3'd1;
        end
        M_EQ, M_LT, M_GT, M_BANG: begin
          nc = (mode_next == M_EQ) ? TkEq : (mode_next == M_LT) ? TkLt :
               (mode_next == M_GT) ? TkGt : TkInvalid;
          res[n[1:0]] = mk(nc, 6'd0, soff_next, COUNT_BITS'(1), line_next,
                           back_col(col_next, COUNT_BITS'(1)));
          n = n + 3'd1;
        end
        default: ;
      endcase
      res[n[1:0]] = mk(TkEnd, 6'd0, bcnt_next, '0, line_next, col_next);
      n = n + 3'd1;
      mode_next  = M_IDLE;
      line_next  = COUNT_BITS'(1);
      col_next   = COUNT_BITS'(1);
      bcnt_next  = '0;
      soff_next  = '0;
      scol_next  = '0;
      run_next   = '0;
      fseen_next = 1'b0;
    end

    if (n != 3'd0) res[2'(n - 3'd1)].last = 1'b1;
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      line  <= COUNT_BITS'(1);
      col   <= COUNT_BITS'(1);
      bcnt  <= '0;
      soff  <= '0;
      scol  <= '0;
      run   <= '0;
      fseen <= 1'b0;
    end else if (fire) begin
      mode  <= mode_next;
      line  <= line_next;
      col   <= col_next;
      bcnt  <= bcnt_next;
      soff  <= soff_next;
      scol  <= scol_next;
      run   <= run_next;
      fseen <= fseen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wen) name_chars[widx] <= wch;
  end

endmodule

>>> rtl/dbst_out_buf.sv
module dbst_out_buf import dbst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  tok_t       items [ResMax],
  input  logic [2:0] cnt,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       free_next,
  output tok_t       head
);

  tok_t       q [ResMax];
  logic [2:0] rem;

  assign out_valid = rem != 3'd0;
  assign head      = q[0];
  // Room for a fresh group once the last queued word leaves.
  assign free_next = (rem == 3'd0) || (rem == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= cnt;
    end else if (out_valid && out_ready) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= items;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < ResMax - 1; i++) q[i] <= q[i+1];
    end
  end

endmodule

>>> bench/dsl_byte_stream_tokenizer_top_test.sv
module dsl_byte_stream_tokenizer_top_test;
  import dbst_pkg::*;

  // Clock, reset and the two channels; every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  token_class;
  logic [5:0]  keyword_index;
  logic [31:0] token_offset;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic        last_of_run;

  dsl_byte_stream_tokenizer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_class(token_class), .keyword_index(keyword_index),
    .token_offset(token_offset), .token_length(token_length),
    .token_line(token_line), .token_column(token_column),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int NameLen = 12;
  localparam int unsigned CountMax = 65535;

  // Tokens still owed by the block, oldest first.
  tok_t        tokens_due[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          tokens_seen = 0;
  int          texts_ended = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Scanner state of the tokenizer as predicted here.
  scan_mode_t  mode;
  int unsigned line_no, col_no, byte_no, tok_start, tok_col, run_len;
  logic [7:0]  name_buf [NameLen];
  bit          is_float;
  tok_t        step_toks[$];

  function automatic int unsigned sat_count(int unsigned v);
    return (v >= CountMax) ? CountMax : v + 1;
  endfunction

  function automatic int unsigned sat_bytes(int unsigned v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void clear_scanner();
    mode = M_IDLE;
    line_no = 1; col_no = 1; byte_no = 0;
    tok_start = 0; tok_col = 0; run_len = 0; is_float = 1'b0;
  endfunction

  function automatic void step_on();
    col_no = sat_count(col_no);
    byte_no = sat_bytes(byte_no);
  endfunction

  function automatic void add_token(logic [4:0] cls, logic [5:0] kw, int unsigned off,
                                    int unsigned len, int unsigned colv);
    tok_t t;
    t.cls = cls; t.kw = kw; t.offset = off; t.length = len[15:0];
    t.line = line_no[15:0]; t.column = colv[15:0]; t.last = 1'b0;
    if (step_toks.size() < ResMax) step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void add_plain(logic [4:0] cls, int unsigned len);
    add_token(cls, 6'd0, tok_start, len, (col_no >= len) ? col_no - len : 0);
  endfunction

  // Keyword lookup: pack the upper-cased name right-aligned like the table text.
  function automatic void add_name();
    logic [87:0] packed_name;
    int unsigned colv;
    colv = (col_no >= run_len) ? col_no - run_len : 0;
    if (run_len <= KwMaxLen) begin
      packed_name = '0;
      for (int i = 0; i < run_len; i++) packed_name = {packed_name[79:0], name_buf[i]};
      for (int k = 0; k < KwCount; k++)
        if (KwLen[k] == run_len && KwText[k] == packed_name) begin
          add_token(TkKeyword, k[5:0], tok_start, run_len, colv);
          return;
        end
    end
    add_token(TkName, 6'd0, tok_start, run_len, colv);
  endfunction

  function automatic void add_dot_after_number();
    add_plain(is_float ? TkFloat : TkInt, run_len);
    tok_start = byte_no;
    step_on();
    add_plain(TkDot, 1);
  endfunction

  function automatic void start_token(logic [7:0] c);
    tok_start = byte_no;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == 8'd10) begin
        line_no = sat_count(line_no);
        col_no = 1;
      end else col_no = sat_count(col_no);
      byte_no = sat_bytes(byte_no);
    end else if (c == "$") begin
      step_on();
      tok_col = col_no;
      mode = M_DOLLAR0;
    end else if (is_alpha(c) || c == "_") begin
      name_buf[0] = upcase(c);
      run_len = 1;
      step_on();
      mode = M_NAME;
    end else if (is_digit(c)) begin
      run_len = 1;
      is_float = 1'b0;
      step_on();
      mode = M_NUM;
    end else if (c == "\"") begin
      step_on();
      tok_start = byte_no;
      run_len = 0;
      mode = M_STR;
    end else begin
      step_on();
      case (c)
        "=": mode = M_EQ;
        "<": mode = M_LT;
        ">": mode = M_GT;
        "!": mode = M_BANG;
        "-": mode = M_DASH;
        "{": add_plain(TkLBrace, 1);
        "}": add_plain(TkRBrace, 1);
        "(": add_plain(TkLParen, 1);
        ")": add_plain(TkRParen, 1);
        "[": add_plain(TkLBracket, 1);
        "]": add_plain(TkRBracket, 1);
        ",": add_plain(TkComma, 1);
        ".": add_plain(TkDot, 1);
        default: add_plain(TkInvalid, 1);
      endcase
    end
  endfunction

  function automatic logic [4:0] lone_op(scan_mode_t m);
    case (m)
      M_EQ:    return TkEq;
      M_LT:    return TkLt;
      M_GT:    return TkGt;
      default: return TkInvalid;
    endcase
  endfunction

  // Offer the byte to the pending token; 1 when it was absorbed.
  function automatic bit continue_token(logic [7:0] c);
    case (mode)
      M_NAME: begin
        if (is_word(c)) begin
          if (run_len < NameLen) name_buf[run_len] = upcase(c);
          run_len = sat_count(run_len);
          step_on();
          return 1'b1;
        end
        add_name();
      end
      M_DOLLAR0: begin
        if (is_alpha(c) || c == "_") begin
          run_len = 1;
          step_on();
          mode = M_DOLLAR;
          return 1'b1;
        end
        add_plain(TkInvalid, 1);
      end
      M_DOLLAR: begin
        if (is_word(c)) begin
          run_len = sat_count(run_len);
          step_on();
          return 1'b1;
        end
        add_token(TkDollar, 6'd0, sat_bytes(tok_start), run_len, tok_col);
      end
      M_NUM_DOT: begin
        if (is_digit(c)) begin
          step_on();
          is_float = 1'b1;
          run_len = sat_count(sat_count(run_len));
          step_on();
          mode = M_NUM;
          return 1'b1;
        end
        add_dot_after_number();
      end
      M_NUM: begin
        if (is_digit(c)) begin
          run_len = sat_count(run_len);
          step_on();
          return 1'b1;
        end
        if (c == "." && !is_float) begin
          mode = M_NUM_DOT;
          return 1'b1;
        end
        if (c == "d" || c == "h" || c == "m") begin
          run_len = sat_count(run_len);
          step_on();
          add_plain(TkTimeUnit, run_len);
          mode = M_IDLE;
          return 1'b1;
        end
        add_plain(is_float ? TkFloat : TkInt, run_len);
      end
      M_STR: begin
        if (c == "\"") begin
          step_on();
          add_plain(TkString, run_len);
          mode = M_IDLE;
          return 1'b1;
        end
        if (c == 8'd10) line_no = sat_count(line_no);
        step_on();
        run_len = sat_count(run_len);
        return 1'b1;
      end
      M_EQ, M_LT, M_GT, M_BANG: begin
        if (c == "=") begin
          step_on();
          case (mode)
            M_EQ:    add_plain(TkEqEq, 2);
            M_LT:    add_plain(TkLe, 2);
            M_GT:    add_plain(TkGe, 2);
            default: add_plain(TkNe, 2);
          endcase
          mode = M_IDLE;
          return 1'b1;
        end
        add_plain(lone_op(mode), 1);
      end
      M_DASH: begin
        if (c == ">") begin
          step_on();
          add_plain(TkArrow, 2);
          mode = M_IDLE;
          return 1'b1;
        end
        add_plain(TkInvalid, 1);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void close_text();
    case (mode)
      M_NAME:    add_name();
      M_DOLLAR0: add_plain(TkInvalid, 1);
      M_DOLLAR:  add_token(TkDollar, 6'd0, sat_bytes(tok_start), run_len, tok_col);
      M_NUM:     add_plain(is_float ? TkFloat : TkInt, run_len);
      M_NUM_DOT: add_dot_after_number();
      M_STR: begin
        // Count the closing quote that never came.
        col_no = sat_count(col_no);
        add_plain(TkString, run_len);
      end
      M_EQ, M_LT, M_GT, M_BANG: add_plain(lone_op(mode), 1);
      M_DASH:    add_plain(TkInvalid, 1);
      default: ;
    endcase
    mode = M_IDLE;
    add_token(TkEnd, 6'd0, byte_no, 0, col_no);
    clear_scanner();
  endfunction

  // Work out every token that one accepted byte releases.
  function automatic void predict_tokens(logic [7:0] c, logic fin);
    step_toks.delete();
    if (!continue_token(c)) begin
      mode = M_IDLE;
      start_token(c);
    end
    if (fin) close_text();
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
  endfunction

  // Predict on each accepted byte before checking the token that leaves at the same edge.
  always @(posedge clk) begin
    tok_t want;
    if (!rst && in_valid && in_ready) begin
      predict_tokens(text_byte, end_of_text);
      words_sent++;
      if (end_of_text) texts_ended++;
    end
    if (!rst && out_valid && out_ready) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: class %0d offset %0d", token_class, token_offset);
      end else begin
        want = tokens_due.pop_front();
        if (token_class !== want.cls || keyword_index !== want.kw ||
            token_offset !== want.offset || token_length !== want.length ||
            token_line !== want.line || token_column !== want.column ||
            last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch at %0t", $time);
            $display("  want cls %0d kw %0d off %0d len %0d line %0d col %0d last %0d",
                     want.cls, want.kw, want.offset, want.length, want.line,
                     want.column, want.last);
            $display("  got  cls %0d kw %0d off %0d len %0d line %0d col %0d last %0d",
                     token_class, keyword_index, token_offset, token_length,
                     token_line, token_column, last_of_run);
          end
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Hand one byte to the block; idle first at the configured rate, then hold until taken.
  task automatic send_word(logic [7:0] b, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++) send_word(s[i], fin && i == s.len() - 1);
  endtask

  // Drop valid and hold off until the block owes nothing.
  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    // keyword with underscore, number then dot then name, lone and named dollars
    send_text("Based_On 1.x2m$ $_v!=-", 0);
    send_word(8'h00, 0);
    send_word(8'hFF, 0);
    // string running over a newline and left open at end of text
    send_text("\"a\nb", 1);
    drain();
  endtask

  // Random source fragment, mostly well-formed tokens.
  task automatic random_fragment(output string s);
    int k;
    string ops [12] = '{"=", "==", "<", "<=", ">", ">=", "!=", "->", "!", "-", "{}", "()[],."};
    s = "";
    case ($urandom_range(11))
      0, 1: begin
        k = $urandom_range(KwCount - 1);
        for (int i = 0; i < KwLen[k]; i++) begin
          byte ch;
          ch = KwText[k][8 * (KwLen[k] - 1 - i) +: 8];
          if ($urandom_range(1) && ch != "_") ch = ch + 8'd32;
          s = {s, string'(ch)};
        end
      end
      2: begin
        s = $urandom_range(1) ? "q" : "_";
        repeat ($urandom_range(16)) s = {s, string'(byte'($urandom_range(1) ? "a" + $urandom_range(25)
                                                        : "0" + $urandom_range(9)))};
      end
      3: begin
        s = "$";
        repeat ($urandom_range(4)) s = {s, string'(byte'("a" + $urandom_range(25)))};
      end
      4, 5: begin
        repeat ($urandom_range(3, 1)) s = {s, string'(byte'("0" + $urandom_range(9)))};
        case ($urandom_range(4))
          0: s = {s, ".", string'(byte'("0" + $urandom_range(9)))};
          1: s = {s, "."};
          2: s = {s, string'(byte'($urandom_range(2) == 0 ? "d" : $urandom_range(1) ? "h" : "m"))};
          default: ;
        endcase
      end
      6: begin
        s = "\"";
        repeat ($urandom_range(5))
          s = {s, string'(byte'(($urandom_range(5) == 0) ? 8'h0A : "x"))};
        if ($urandom_range(4) != 0) s = {s, "\""};
      end
      7, 8: s = ops[$urandom_range(11)];
      9: s = $urandom_range(2) == 0 ? "\n" : $urandom_range(1) ? " " : "\t";
      default: s = string'(byte'($urandom_range(255)));
    endcase
  endtask

  task automatic test_random(int count);
    string frag;
    int sent;
    sent = 0;
    while (sent < count) begin
      random_fragment(frag);
      if (frag.len() == 0) frag = " ";
      for (int i = 0; i < frag.len(); i++) begin
        // byte 0 cannot sit in a string literal, so send a raw zero now and then
        send_word($urandom_range(60) == 0 ? 8'h00 : frag[i], $urandom_range(29) == 0);
        sent++;
      end
      if ($urandom_range(3) == 0) begin
        send_word(" ", 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    clear_scanner();
    send_idle_pct = 27; recv_idle_pct = 49;
    test_directed();
    test_random(150);
    // Pause the sender until every owed token has left.
    drain();
    send_idle_pct = 49; recv_idle_pct = 27;
    test_random(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(150);
    send_text(" end", 1);
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d bytes in %0d texts, checked %0d tokens over three idling mixes",
             words_sent, texts_ended, tokens_seen);
    if (mismatches == 0 && tokens_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout with %0d tokens owed", tokens_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
